// ----- hw/rtl/fsgs_pkg.sv -----
package fsgs_pkg;

    localparam int MAX_WIDTH_DEF   = 256;
    localparam int MAX_HEIGHT_DEF  = 256;
    localparam int CELL_PIXELS_DEF = 10;

    localparam int POS_W     = 16;
    localparam int CMD_W     = 2;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_W-1:0] GRID_SIZE_RESET = 9'd256;

    // command codes; the fourth code is unknown and only answered
    localparam logic [CMD_W-1:0] CMD_PLACE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STEP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

    typedef struct packed {
        logic kind;
        logic occ;
    } cell_t;

    // neighbour probed relative to the cell being swept
    typedef enum logic [2:0] {
        DIR_BELOW,
        DIR_DL,
        DIR_DR,
        DIR_R,
        DIR_L
    } dir_t;

    typedef enum logic [1:0] {
        RD_SRC,
        RD_NB,
        RD_POS
    } rd_sel_t;

    typedef enum logic [1:0] {
        WA_CLEAR,
        WA_PLACE,
        WA_NB,
        WA_SRC
    } wa_sel_t;

    typedef enum logic [2:0] {
        WD_ZERO,
        WD_PLACE,
        WD_MOVED,
        WD_SAND,
        WD_WATER
    } wd_sel_t;

    typedef struct packed {
        logic    load_item;
        logic    re;
        rd_sel_t rd_sel;
        logic    we;
        wa_sel_t wa_sel;
        wd_sel_t wd_sel;
        dir_t    dir;
        logic    clr_step;
        logic    sweep_init;
        logic    adv;
        logic    cap_src;
        logic    cap_below;
        logic    set_skip;
        logic    clr_skip;
        logic    load_rsp;
    } dp_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             in_range;
        logic             rd_occ;
        logic             src_kind;
        logic             below_water;
        logic             nb_avail;
        logic             skip;
        logic             last_cell;
        logic             clr_last;
        logic             rsp_free;
    } dp_sts_t;

endpackage

// ----- hw/rtl/fsgs_req_if.sv -----
interface fsgs_req_if;

    logic                                 valid;
    logic                                 ready;
    logic [fsgs_pkg::CMD_W-1:0]           cmd;
    logic signed [fsgs_pkg::POS_W-1:0]    pos_x;
    logic signed [fsgs_pkg::POS_W-1:0]    pos_y;
    logic                                 particle_kind;

    modport source (
        output valid,
        output cmd,
        output pos_x,
        output pos_y,
        output particle_kind,
        input  ready
    );

    modport sink (
        input  valid,
        input  cmd,
        input  pos_x,
        input  pos_y,
        input  particle_kind,
        output ready
    );

endinterface

// ----- hw/rtl/fsgs_rsp_if.sv -----
interface fsgs_rsp_if;

    logic valid;
    logic ready;
    logic cell_occupied;
    logic cell_kind;
    logic command_done;

    modport source (
        output valid,
        output cell_occupied,
        output cell_kind,
        output command_done,
        input  ready
    );

    modport sink (
        input  valid,
        input  cell_occupied,
        input  cell_kind,
        input  command_done,
        output ready
    );

endinterface

// ----- hw/rtl/fsgs_ram.sv -----
module fsgs_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/fsgs_ctrl.sv -----
module fsgs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  fsgs_pkg::dp_sts_t sts,
    output fsgs_pkg::dp_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_PLACE_WR,
        S_CELL_RD,
        S_CELL_CHK,
        S_PROBE_RD,
        S_PROBE_CHK,
        S_MOVE_DST,
        S_MOVE_SRC,
        S_SWAP_BELOW,
        S_SWAP_SRC,
        S_ADV,
        S_RESP
    } state_t;

    state_t          state_reg;
    state_t          state_next;
    fsgs_pkg::dir_t  dir_reg;
    fsgs_pkg::dir_t  dir_next;
    state_t          fail_state;
    fsgs_pkg::dir_t  fail_dir;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            dir_reg   <= fsgs_pkg::DIR_BELOW;
        end
        else
        begin
            state_reg <= state_next;
            dir_reg   <= dir_next;
        end
    end

    // where to go when the current neighbour is missing or taken
    always_comb
    begin
        fail_state = S_PROBE_RD;
        fail_dir   = dir_reg;
        unique case (dir_reg)
            fsgs_pkg::DIR_BELOW: fail_dir = fsgs_pkg::DIR_DL;
            fsgs_pkg::DIR_DL:    fail_dir = fsgs_pkg::DIR_DR;
            fsgs_pkg::DIR_DR:
            begin
                if (sts.src_kind)
                begin
                    fail_dir = fsgs_pkg::DIR_R;
                end
                else if (sts.below_water)
                begin
                    fail_dir   = fsgs_pkg::DIR_BELOW;
                    fail_state = S_SWAP_BELOW;
                end
                else
                begin
                    fail_state = S_ADV;
                end
            end
            fsgs_pkg::DIR_R:     fail_dir = fsgs_pkg::DIR_L;
            fsgs_pkg::DIR_L:     fail_state = S_ADV;
            default:             fail_state = S_ADV;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        dir_next   = dir_reg;
        req_ready  = 1'b0;
        cmd        = '0;
        cmd.dir    = dir_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.we       = 1'b1;
                cmd.wa_sel   = fsgs_pkg::WA_CLEAR;
                cmd.wd_sel   = fsgs_pkg::WD_ZERO;
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                priority case (sts.cmd)
                    fsgs_pkg::CMD_PLACE: state_next = S_PLACE_WR;
                    fsgs_pkg::CMD_STEP:
                    begin
                        cmd.sweep_init = 1'b1;
                        state_next     = S_CELL_RD;
                    end
                    fsgs_pkg::CMD_READ:
                    begin
                        cmd.re     = sts.in_range;
                        cmd.rd_sel = fsgs_pkg::RD_POS;
                        state_next = S_RESP;
                    end
                    default:             state_next = S_RESP;
                endcase
            end
            S_PLACE_WR:
            begin
                cmd.we     = 1'b1;
                cmd.wa_sel = fsgs_pkg::WA_PLACE;
                cmd.wd_sel = fsgs_pkg::WD_PLACE;
                state_next = S_RESP;
            end
            S_CELL_RD:
            begin
                if (sts.skip)
                begin
                    cmd.clr_skip = 1'b1;
                    state_next   = S_ADV;
                end
                else
                begin
                    cmd.re     = 1'b1;
                    cmd.rd_sel = fsgs_pkg::RD_SRC;
                    state_next = S_CELL_CHK;
                end
            end
            S_CELL_CHK:
            begin
                cmd.cap_src = 1'b1;
                if (sts.rd_occ)
                begin
                    dir_next   = fsgs_pkg::DIR_BELOW;
                    state_next = S_PROBE_RD;
                end
                else
                begin
                    state_next = S_ADV;
                end
            end
            S_PROBE_RD:
            begin
                if (sts.nb_avail)
                begin
                    cmd.re     = 1'b1;
                    cmd.rd_sel = fsgs_pkg::RD_NB;
                    state_next = S_PROBE_CHK;
                end
                else
                begin
                    state_next = fail_state;
                    dir_next   = fail_dir;
                end
            end
            S_PROBE_CHK:
            begin
                cmd.cap_below = (dir_reg == fsgs_pkg::DIR_BELOW);
                if (!sts.rd_occ)
                begin
                    state_next = S_MOVE_DST;
                end
                else
                begin
                    state_next = fail_state;
                    dir_next   = fail_dir;
                end
            end
            S_MOVE_DST:
            begin
                cmd.we       = 1'b1;
                cmd.wa_sel   = fsgs_pkg::WA_NB;
                cmd.wd_sel   = fsgs_pkg::WD_MOVED;
                // a particle moved right must not be swept again at its new place
                cmd.set_skip = (dir_reg == fsgs_pkg::DIR_R);
                state_next   = S_MOVE_SRC;
            end
            S_MOVE_SRC:
            begin
                cmd.we     = 1'b1;
                cmd.wa_sel = fsgs_pkg::WA_SRC;
                cmd.wd_sel = fsgs_pkg::WD_ZERO;
                state_next = S_ADV;
            end
            S_SWAP_BELOW:
            begin
                cmd.we     = 1'b1;
                cmd.wa_sel = fsgs_pkg::WA_NB;
                cmd.wd_sel = fsgs_pkg::WD_SAND;
                state_next = S_SWAP_SRC;
            end
            S_SWAP_SRC:
            begin
                cmd.we     = 1'b1;
                cmd.wa_sel = fsgs_pkg::WA_SRC;
                cmd.wd_sel = fsgs_pkg::WD_WATER;
                state_next = S_ADV;
            end
            S_ADV:
            begin
                if (sts.last_cell)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.adv    = 1'b1;
                    state_next = S_CELL_RD;
                end
            end
            S_RESP:
            begin
                if (sts.rsp_free)
                begin
                    cmd.load_rsp = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ----- hw/rtl/fsgs_dp.sv -----
module fsgs_dp #(
    parameter int MAX_WIDTH   = fsgs_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = fsgs_pkg::MAX_HEIGHT_DEF,
    parameter int CELL_PIXELS = fsgs_pkg::CELL_PIXELS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [fsgs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fsgs_pkg::CFG_W-1:0]          cfg_data,
    input  logic [fsgs_pkg::CMD_W-1:0]          req_cmd,
    input  logic signed [fsgs_pkg::POS_W-1:0]   req_pos_x,
    input  logic signed [fsgs_pkg::POS_W-1:0]   req_pos_y,
    input  logic                                req_kind,
    input  logic                                rsp_ready,
    output logic                                rsp_valid,
    output logic                                rsp_occupied,
    output logic                                rsp_kind,
    output logic                                rsp_done,
    input  fsgs_pkg::dp_cmd_t                   cmd,
    output fsgs_pkg::dp_sts_t                   sts
);

    localparam int PW    = fsgs_pkg::POS_W;
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int AW    = XW + YW;
    localparam int DEPTH = MAX_HEIGHT << XW;
    localparam int SW_W  = $clog2(MAX_WIDTH + 1);
    localparam int SH_W  = $clog2(MAX_HEIGHT + 1);
    localparam int CW    = (SW_W > fsgs_pkg::CFG_W) ? SW_W : fsgs_pkg::CFG_W;
    localparam int CH    = (SH_W > fsgs_pkg::CFG_W) ? SH_W : fsgs_pkg::CFG_W;

    // reciprocal multiply: exact floor division for any 16-bit magnitude
    localparam int              DIV_L  = $clog2(CELL_PIXELS);
    localparam int              DIV_S  = PW + DIV_L;
    localparam longint unsigned DIV_M  = ((64'd1 << DIV_S) + CELL_PIXELS - 1) / CELL_PIXELS;
    localparam int              MW     = PW + 1;
    localparam int              PRW    = PW + MW;
    localparam logic [MW-1:0]   DIV_MV = MW'(DIV_M);

    logic [fsgs_pkg::CFG_W-1:0] grid_width_reg;
    logic [fsgs_pkg::CFG_W-1:0] grid_height_reg;
    logic [SW_W-1:0]            eff_w;
    logic [SH_W-1:0]            eff_h;
    logic [CW-1:0]              gw_ext;
    logic [CH-1:0]              gh_ext;

    logic [fsgs_pkg::CMD_W-1:0] cmd_reg;
    logic signed [PW-1:0]       pos_x_reg;
    logic signed [PW-1:0]       pos_y_reg;
    logic                       kind_reg;

    logic [PW-1:0]              mag_x;
    logic [PW-1:0]              mag_y;
    logic [PRW-1:0]             prod_x_reg;
    logic [PRW-1:0]             prod_y_reg;
    logic                       neg_x_reg;
    logic                       neg_y_reg;
    logic [PW-1:0]              place_x;
    logic [PW-1:0]              place_y;

    logic [YW-1:0]              y_reg;
    logic [XW-1:0]              x_reg;
    logic [AW-1:0]              clr_addr_reg;
    logic                       skip_reg;
    fsgs_pkg::cell_t            src_reg;
    fsgs_pkg::cell_t            below_reg;

    logic [YW-1:0]              ny;
    logic [XW-1:0]              nx;
    logic                       at_left;
    logic                       at_right;
    logic                       in_range;
    logic                       nb_avail;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    fsgs_pkg::cell_t            ram_wdata;
    logic [AW-1:0]              ram_raddr;
    logic [$bits(fsgs_pkg::cell_t)-1:0] ram_rdata;
    fsgs_pkg::cell_t            rd_cell;

    logic                       rsp_valid_reg;
    logic                       rsp_occ_reg;
    logic                       rsp_kind_reg;
    logic                       rsp_done_reg;

    function automatic logic [PW-1:0] clamp_pos(
        input logic [PW-1:0] q,
        input logic          neg,
        input logic [PW-1:0] size
    );
        logic [PW-1:0] r;
        if (neg && (q != '0))
        begin
            r = PW'(1);
        end
        else if (q >= size)
        begin
            r = size - PW'(1);
        end
        else
        begin
            r = q;
        end
        return r;
    endfunction

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= fsgs_pkg::GRID_SIZE_RESET;
            grid_height_reg <= fsgs_pkg::GRID_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fsgs_pkg::REG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                fsgs_pkg::REG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                default:                   grid_width_reg  <= grid_width_reg;
            endcase
        end
    end

    // sizes in use: below 2 acts as 2, above the maximum acts as the maximum
    always_comb
    begin
        gw_ext = CW'(grid_width_reg);
        gh_ext = CH'(grid_height_reg);
        if (gw_ext < CW'(2))
        begin
            eff_w = SW_W'(2);
        end
        else if (gw_ext > CW'(MAX_WIDTH))
        begin
            eff_w = SW_W'(MAX_WIDTH);
        end
        else
        begin
            eff_w = SW_W'(gw_ext);
        end
        if (gh_ext < CH'(2))
        begin
            eff_h = SH_W'(2);
        end
        else if (gh_ext > CH'(MAX_HEIGHT))
        begin
            eff_h = SH_W'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = SH_W'(gh_ext);
        end
    end

    // accepted word
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            cmd_reg   <= req_cmd;
            pos_x_reg <= req_pos_x;
            pos_y_reg <= req_pos_y;
            kind_reg  <= req_kind;
        end
    end

    // pixel to cell: magnitude times reciprocal, registered before the clamp
    assign mag_x = pos_x_reg[PW-1] ? (PW'(0) - $unsigned(pos_x_reg)) : $unsigned(pos_x_reg);
    assign mag_y = pos_y_reg[PW-1] ? (PW'(0) - $unsigned(pos_y_reg)) : $unsigned(pos_y_reg);

    always_ff @(posedge clk)
    begin
        prod_x_reg <= PRW'(mag_x) * PRW'(DIV_MV);
        prod_y_reg <= PRW'(mag_y) * PRW'(DIV_MV);
        neg_x_reg  <= pos_x_reg[PW-1];
        neg_y_reg  <= pos_y_reg[PW-1];
    end

    assign place_x = clamp_pos(PW'(prod_x_reg >> DIV_S), neg_x_reg, PW'(eff_w));
    assign place_y = clamp_pos(PW'(prod_y_reg >> DIV_S), neg_y_reg, PW'(eff_h));

    assign in_range = !pos_x_reg[PW-1] && ($unsigned(pos_x_reg) < PW'(eff_w)) &&
                      !pos_y_reg[PW-1] && ($unsigned(pos_y_reg) < PW'(eff_h));

    // sweep position, from the row above the bottom row upward, left to right
    assign at_left  = (x_reg == '0);
    assign at_right = (SW_W'(x_reg) == (eff_w - SW_W'(1)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y_reg        <= '0;
            x_reg        <= '0;
            clr_addr_reg <= '0;
            skip_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.sweep_init)
            begin
                y_reg <= YW'(eff_h - SH_W'(2));
                x_reg <= '0;
            end
            else if (cmd.adv)
            begin
                if (at_right)
                begin
                    x_reg <= '0;
                    y_reg <= y_reg - YW'(1);
                end
                else
                begin
                    x_reg <= x_reg + XW'(1);
                end
            end
            if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (cmd.sweep_init || cmd.clr_skip)
            begin
                skip_reg <= 1'b0;
            end
            else if (cmd.set_skip)
            begin
                skip_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_src)
        begin
            src_reg <= rd_cell;
        end
        if (cmd.cap_below)
        begin
            below_reg <= rd_cell;
        end
    end

    // neighbour address
    always_comb
    begin
        ny = y_reg;
        nx = x_reg;
        unique case (cmd.dir)
            fsgs_pkg::DIR_BELOW:
            begin
                ny = y_reg + YW'(1);
            end
            fsgs_pkg::DIR_DL:
            begin
                ny = y_reg + YW'(1);
                nx = x_reg - XW'(1);
            end
            fsgs_pkg::DIR_DR:
            begin
                ny = y_reg + YW'(1);
                nx = x_reg + XW'(1);
            end
            fsgs_pkg::DIR_R: nx = x_reg + XW'(1);
            fsgs_pkg::DIR_L: nx = x_reg - XW'(1);
            default:         nx = x_reg;
        endcase
    end

    always_comb
    begin
        unique case (cmd.dir)
            fsgs_pkg::DIR_DL, fsgs_pkg::DIR_L: nb_avail = !at_left;
            fsgs_pkg::DIR_DR, fsgs_pkg::DIR_R: nb_avail = !at_right;
            default:                           nb_avail = 1'b1;
        endcase
    end

    // memory ports
    always_comb
    begin
        unique case (cmd.rd_sel)
            fsgs_pkg::RD_SRC: ram_raddr = {y_reg, x_reg};
            fsgs_pkg::RD_NB:  ram_raddr = {ny, nx};
            fsgs_pkg::RD_POS: ram_raddr = {pos_y_reg[YW-1:0], pos_x_reg[XW-1:0]};
            default:          ram_raddr = {y_reg, x_reg};
        endcase
        unique case (cmd.wa_sel)
            fsgs_pkg::WA_CLEAR: ram_waddr = clr_addr_reg;
            fsgs_pkg::WA_PLACE: ram_waddr = {place_y[YW-1:0], place_x[XW-1:0]};
            fsgs_pkg::WA_NB:    ram_waddr = {ny, nx};
            fsgs_pkg::WA_SRC:   ram_waddr = {y_reg, x_reg};
            default:            ram_waddr = clr_addr_reg;
        endcase
        unique case (cmd.wd_sel)
            fsgs_pkg::WD_ZERO:  ram_wdata = '0;
            fsgs_pkg::WD_PLACE: ram_wdata = '{kind: kind_reg, occ: 1'b1};
            fsgs_pkg::WD_MOVED: ram_wdata = '{kind: src_reg.kind, occ: 1'b1};
            fsgs_pkg::WD_SAND:  ram_wdata = '{kind: 1'b0, occ: 1'b1};
            fsgs_pkg::WD_WATER: ram_wdata = '{kind: 1'b1, occ: 1'b1};
            default:            ram_wdata = '0;
        endcase
    end

    assign ram_we = cmd.we;

    fsgs_ram #(
        .WIDTH ($bits(fsgs_pkg::cell_t)),
        .DEPTH (DEPTH)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_cell = ram_rdata;

    // result word; the next command may be taken while this one waits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.load_rsp)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_rsp)
        begin
            rsp_occ_reg  <= (cmd_reg == fsgs_pkg::CMD_READ) && in_range && rd_cell.occ;
            rsp_kind_reg <= (cmd_reg == fsgs_pkg::CMD_READ) && in_range && rd_cell.occ &&
                            rd_cell.kind;
            rsp_done_reg <= (cmd_reg == fsgs_pkg::CMD_PLACE) ||
                            (cmd_reg == fsgs_pkg::CMD_STEP) ||
                            (cmd_reg == fsgs_pkg::CMD_READ);
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign rsp_occupied = rsp_occ_reg;
    assign rsp_kind     = rsp_kind_reg;
    assign rsp_done     = rsp_done_reg;

    assign sts.cmd         = cmd_reg;
    assign sts.in_range    = in_range;
    assign sts.rd_occ      = rd_cell.occ;
    assign sts.src_kind    = src_reg.kind;
    assign sts.below_water = below_reg.occ && below_reg.kind;
    assign sts.nb_avail    = nb_avail;
    assign sts.skip        = skip_reg;
    assign sts.last_cell   = (y_reg == '0) && at_right;
    assign sts.clr_last    = (clr_addr_reg == AW'(DEPTH - 1));
    assign sts.rsp_free    = !rsp_valid_reg || rsp_ready;

endmodule

// ----- hw/rtl/falling_sand_grid_step_top.sv -----
// Place: the accepted word passes the decode, write and response states before its result
// word; read and unknown command: the decode and response states. Step: width x (height-1)
// cells are swept one at a time through the single read port of the cell memory.
// Reset: grid size 256 x 256; then a clearing pass writes every cell of the memory,
// MAX_HEIGHT x 2^ceil(log2 MAX_WIDTH) cells (65536 by default), with no word accepted.
// Configuration writes are taken in any cycle; one command is in progress at a time.
module falling_sand_grid_step_top #(
    parameter int MAX_WIDTH   = fsgs_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = fsgs_pkg::MAX_HEIGHT_DEF,
    parameter int CELL_PIXELS = fsgs_pkg::CELL_PIXELS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [fsgs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fsgs_pkg::CFG_W-1:0]     cfg_data,
    fsgs_req_if.sink                       req,
    fsgs_rsp_if.source                     rsp
);

    fsgs_pkg::dp_cmd_t dp_cmd;
    fsgs_pkg::dp_sts_t dp_sts;

    fsgs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (dp_sts),
        .cmd       (dp_cmd)
    );

    fsgs_dp #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .CELL_PIXELS (CELL_PIXELS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req_cmd      (req.cmd),
        .req_pos_x    (req.pos_x),
        .req_pos_y    (req.pos_y),
        .req_kind     (req.particle_kind),
        .rsp_ready    (rsp.ready),
        .rsp_valid    (rsp.valid),
        .rsp_occupied (rsp.cell_occupied),
        .rsp_kind     (rsp.cell_kind),
        .rsp_done     (rsp.command_done),
        .cmd          (dp_cmd),
        .sts          (dp_sts)
    );

endmodule

// ----- verif/tb_falling_sand_grid_step_top.sv -----
`timescale 1ns / 100ps

module tb_falling_sand_grid_step_top;

    localparam logic [fsgs_pkg::CMD_W-1:0] CMD_UNKNOWN = 2'd3;

    // one cell of the grid model: kind and occupancy as the block keeps them, plus a mark for moved grains
    typedef struct packed {
        bit mark;
        bit kind;
        bit occ;
    } sand_cell_t;

    typedef struct {
        logic [fsgs_pkg::CMD_W-1:0]        cmd;
        logic signed [fsgs_pkg::POS_W-1:0] pos_x;
        logic signed [fsgs_pkg::POS_W-1:0] pos_y;
        logic                              kind;
    } grid_cmd_t;

    typedef struct packed {
        logic occupied;
        logic kind;
        logic done;
    } cell_rsp_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [fsgs_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [fsgs_pkg::CFG_W-1:0]     cfg_data;

    fsgs_req_if req_ch ();
    fsgs_rsp_if rsp_ch ();

    falling_sand_grid_step_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    sand_cell_t grid_model [fsgs_pkg::MAX_HEIGHT_DEF][fsgs_pkg::MAX_WIDTH_DEF];
    logic [fsgs_pkg::CFG_W-1:0] grid_w_reg = fsgs_pkg::GRID_SIZE_RESET;
    logic [fsgs_pkg::CFG_W-1:0] grid_h_reg = fsgs_pkg::GRID_SIZE_RESET;
    cell_rsp_t                  pending_rsp [$];
    int                         mismatch_count = 0;
    bit                         no_idle = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(20_000_000);
        $display("FAILED: results differ");
        $finish;
    end

    function automatic int eff_dim(logic [fsgs_pkg::CFG_W-1:0] v, int max_dim);
        if (v < 2)
            return 2;
        if (v > max_dim)
            return max_dim;
        return int'(v);
    endfunction

    function automatic bit try_move(int y, int x, int ny, int nx);
        if (grid_model[ny][nx].occ)
            return 1'b0;
        grid_model[ny][nx] = '{mark: 1'b1, kind: grid_model[y][x].kind, occ: 1'b1};
        grid_model[y][x].occ = 1'b0;
        return 1'b1;
    endfunction

    function automatic void sweep_grid(int gw, int gh);
        sand_cell_t c;
        bit         has_l;
        bit         has_r;
        for (int y = gh - 2; y >= 0; y--)
        begin
            for (int x = 0; x < gw; x++)
            begin
                c = grid_model[y][x];
                has_l = (x != 0);
                has_r = (x != gw - 1);
                if (!c.occ || c.mark)
                    continue;
                if (try_move(y, x, y + 1, x))
                    continue;
                if (has_l && try_move(y, x, y + 1, x - 1))
                    continue;
                if (has_r && try_move(y, x, y + 1, x + 1))
                    continue;
                if (!c.kind)
                begin
                    // sand sinks: swap kinds with the water below, no marks
                    if (grid_model[y + 1][x].occ && grid_model[y + 1][x].kind)
                    begin
                        grid_model[y + 1][x].kind = 1'b0;
                        grid_model[y][x].kind = 1'b1;
                    end
                end
                else if (!(has_r && try_move(y, x, y, x + 1)) && has_l)
                    void'(try_move(y, x, y, x - 1));
            end
        end
        // marks can only have been set inside the swept area
        for (int y = 0; y < gh; y++)
            for (int x = 0; x < gw; x++)
                grid_model[y][x].mark = 1'b0;
    endfunction

    function automatic cell_rsp_t predict_cell_rsp(grid_cmd_t w);
        cell_rsp_t r;
        int        gw;
        int        gh;
        int        cx;
        int        cy;
        gw = eff_dim(grid_w_reg, fsgs_pkg::MAX_WIDTH_DEF);
        gh = eff_dim(grid_h_reg, fsgs_pkg::MAX_HEIGHT_DEF);
        r = '0;
        case (w.cmd)
            fsgs_pkg::CMD_PLACE:
            begin
                cx = int'(w.pos_x) / fsgs_pkg::CELL_PIXELS_DEF;
                cy = int'(w.pos_y) / fsgs_pkg::CELL_PIXELS_DEF;
                if (cx >= gw) cx = gw - 1;
                if (cx < 0)   cx = 1;
                if (cy >= gh) cy = gh - 1;
                if (cy < 0)   cy = 1;
                grid_model[cy][cx] = '{mark: 1'b0, kind: w.kind, occ: 1'b1};
                r.done = 1'b1;
            end
            fsgs_pkg::CMD_STEP:
            begin
                sweep_grid(gw, gh);
                r.done = 1'b1;
            end
            fsgs_pkg::CMD_READ:
            begin
                cx = int'(w.pos_x);
                cy = int'(w.pos_y);
                if (cx >= 0 && cx < gw && cy >= 0 && cy < gh && grid_model[cy][cx].occ)
                begin
                    r.occupied = 1'b1;
                    r.kind = grid_model[cy][cx].kind;
                end
                r.done = 1'b1;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic grid_cmd_t make_word(logic [fsgs_pkg::CMD_W-1:0] cmd,
                                            logic signed [fsgs_pkg::POS_W-1:0] x,
                                            logic signed [fsgs_pkg::POS_W-1:0] y,
                                            logic kind);
        grid_cmd_t w;
        w.cmd = cmd;
        w.pos_x = x;
        w.pos_y = y;
        w.kind = kind;
        return w;
    endfunction

    task automatic send_word(grid_cmd_t w);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.cmd           <= w.cmd;
        req_ch.pos_x         <= w.pos_x;
        req_ch.pos_y         <= w.pos_y;
        req_ch.particle_kind <= w.kind;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_rsp = {pending_rsp, predict_cell_rsp(w)};
    endtask

    // drop valid, hold until every result word is back, then let the block settle
    task automatic drain_results(int settle);
        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic set_grid(logic [fsgs_pkg::CFG_W-1:0] gw_raw,
                            logic [fsgs_pkg::CFG_W-1:0] gh_raw);
        drain_results(8);
        cfg_we    <= 1'b1;
        cfg_index <= fsgs_pkg::REG_GRID_WIDTH;
        cfg_data  <= gw_raw;
        @(posedge clk);
        cfg_index <= fsgs_pkg::REG_GRID_HEIGHT;
        cfg_data  <= gh_raw;
        @(posedge clk);
        cfg_we <= 1'b0;
        grid_w_reg = gw_raw;
        grid_h_reg = gh_raw;
    endtask

    task automatic check_field(string name, logic want, logic got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0b got %0b", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    initial
    begin : rsp_checker
        cell_rsp_t want;
        cell_rsp_t got;
        int        hold;
        hold = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                got = '{rsp_ch.cell_occupied, rsp_ch.cell_kind, rsp_ch.command_done};
                if (pending_rsp.size() == 0)
                begin
                    $display("%0t: result word with none expected, got %b", $time, got);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    check_field("cell_occupied", want.occupied, got.occupied);
                    check_field("cell_kind", want.kind, got.kind);
                    check_field("command_done", want.done, got.done);
                end
                hold = no_idle ? 0 : $urandom_range(0, 7);
            end
            if (hold > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold--;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // full-size grid after reset: clamping, truncation toward zero, reads off the grid
    task automatic test_default_grid();
        send_word(make_word(fsgs_pkg::CMD_PLACE, 32767, 32767, 1'b1));
        send_word(make_word(fsgs_pkg::CMD_READ, 255, 255, 1'b0));
        send_word(make_word(fsgs_pkg::CMD_PLACE, -32768, -32768, 1'b0));
        send_word(make_word(fsgs_pkg::CMD_READ, 1, 1, 1'b1));
        send_word(make_word(fsgs_pkg::CMD_PLACE, -5, 9, 1'b1));
        send_word(make_word(fsgs_pkg::CMD_READ, 0, 0, 1'b0));
        send_word(make_word(fsgs_pkg::CMD_READ, 256, 0, 1'b0));
        send_word(make_word(fsgs_pkg::CMD_READ, -1, 5, 1'b0));
        send_word(make_word(fsgs_pkg::CMD_READ, 2, 2, 1'b0));
        send_word(make_word(CMD_UNKNOWN, -1, -1, 1'b1));
    endtask

    // small grid: sinking sand, water blocked on every side and edge columns
    task automatic test_directed_moves();
        set_grid(9'd3, 9'd3);
        send_word(make_word(fsgs_pkg::CMD_PLACE, 5, 25, 1'b1));
        send_word(make_word(fsgs_pkg::CMD_PLACE, 15, 25, 1'b1));
        send_word(make_word(fsgs_pkg::CMD_PLACE, 25, 25, 1'b1));
        send_word(make_word(fsgs_pkg::CMD_PLACE, 15, 15, 1'b0));
        send_word(make_word(fsgs_pkg::CMD_PLACE, 5, 15, 1'b1));
        send_word(make_word(fsgs_pkg::CMD_PLACE, 25, 5, 1'b0));
        send_word(make_word(fsgs_pkg::CMD_STEP, 0, 0, 1'b0));
        send_word(make_word(fsgs_pkg::CMD_STEP, 0, 0, 1'b0));
        for (int y = 0; y < 3; y++)
            for (int x = 0; x < 3; x++)
                send_word(make_word(fsgs_pkg::CMD_READ, 16'(x), 16'(y), 1'b0));
    endtask

    // sizes past both ends; cells outside the size in use must survive
    task automatic test_size_extremes();
        set_grid(9'd511, 9'd0);
        send_word(make_word(fsgs_pkg::CMD_PLACE, 2559, 0, 1'b0));
        send_word(make_word(fsgs_pkg::CMD_PLACE, -10, 19, 1'b1));
        send_word(make_word(fsgs_pkg::CMD_STEP, 0, 0, 1'b0));
        send_word(make_word(fsgs_pkg::CMD_READ, 255, 1, 1'b0));
        send_word(make_word(fsgs_pkg::CMD_READ, 255, 0, 1'b0));
        send_word(make_word(fsgs_pkg::CMD_READ, 1, 1, 1'b0));
        set_grid(9'd1, 9'd256);
        send_word(make_word(fsgs_pkg::CMD_PLACE, 32767, 0, 1'b1));
        send_word(make_word(fsgs_pkg::CMD_PLACE, 0, 32767, 1'b0));
        send_word(make_word(fsgs_pkg::CMD_STEP, 0, 0, 1'b0));
        send_word(make_word(fsgs_pkg::CMD_READ, 1, 1, 1'b0));
        send_word(make_word(fsgs_pkg::CMD_READ, 0, 255, 1'b0));
        send_word(make_word(fsgs_pkg::CMD_READ, 255, 1, 1'b0));
        send_word(make_word(fsgs_pkg::CMD_READ, 0, 256, 1'b0));
        set_grid(9'd256, 9'd300);
        send_word(make_word(fsgs_pkg::CMD_READ, 255, 1, 1'b0));
        send_word(make_word(fsgs_pkg::CMD_READ, 1, 1, 1'b0));
    endtask

    task automatic test_random_phase(int n_items, int max_dim, bit quiet);
        grid_cmd_t w;
        int        gw;
        int        gh;
        int        pick;
        set_grid(9'($urandom_range(2, max_dim)), 9'($urandom_range(2, max_dim)));
        gw = eff_dim(grid_w_reg, fsgs_pkg::MAX_WIDTH_DEF);
        gh = eff_dim(grid_h_reg, fsgs_pkg::MAX_HEIGHT_DEF);
        no_idle = quiet;
        for (int i = 0; i < n_items; i++)
        begin
            if (i == n_items / 2)
                drain_results(0);
            pick = $urandom_range(0, 99);
            w = make_word(fsgs_pkg::CMD_READ, 16'($urandom_range(0, gw)),
                          16'($urandom_range(0, gh)), 1'($urandom_range(0, 1)));
            if (pick < 40)
            begin
                // drop grains into the upper half so they have room to fall
                w.cmd = fsgs_pkg::CMD_PLACE;
                w.pos_x = 16'($urandom_range(0, gw * fsgs_pkg::CELL_PIXELS_DEF + 9));
                w.pos_y = 16'($urandom_range(0, gh * fsgs_pkg::CELL_PIXELS_DEF / 2));
            end
            else if (pick < 60)
                w.cmd = fsgs_pkg::CMD_STEP;
            else if (pick < 64)
                w.cmd = CMD_UNKNOWN;
            if ($urandom_range(0, 9) == 0)
            begin
                w.pos_x = 16'($urandom);
                w.pos_y = 16'($urandom);
            end
            send_word(w);
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= fsgs_pkg::REG_GRID_WIDTH;
        cfg_data             <= '0;
        req_ch.valid         <= 1'b0;
        req_ch.cmd           <= fsgs_pkg::CMD_PLACE;
        req_ch.pos_x         <= '0;
        req_ch.pos_y         <= '0;
        req_ch.particle_kind <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_default_grid();
        test_directed_moves();
        test_size_extremes();
        test_random_phase(12, 6, 1'b0);
        test_random_phase(12, 8, 1'b1);
        test_random_phase(12, 4, 1'b0);
        test_random_phase(14, 16, 1'b0);
        test_random_phase(14, 8, 1'b0);

        drain_results(20);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
